>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked outside of reset.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Property checked on every edge, reset included.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) \
    else $error(msg);

`endif

>>> sv/playf_pkg.sv
// ---------------------------------------------------------------------------
// playf_pkg
// Shared constants, types and helpers for the Playfair digraph cipher unit.
// ---------------------------------------------------------------------------
`default_nettype none

package playf_pkg;

  localparam int SIDE      = 5;
  localparam int CELLS     = SIDE * SIDE;
  localparam int LETTERS   = 26;
  localparam int LETTER_W  = 5;
  localparam int CELL_AW   = $clog2(CELLS);
  localparam int LETTER_AW = $clog2(LETTERS);
  localparam int RC_W      = $clog2(SIDE) + 1;
  localparam int FILL_W    = $clog2(CELLS + 1);

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [CELL_AW-1:0]  cell_addr_t;
  typedef logic [RC_W-1:0]     rc_t;

  localparam letter_t LETTER_I = letter_t'(8);
  localparam letter_t LETTER_J = letter_t'(9);
  localparam letter_t LETTER_Z = letter_t'(LETTERS - 1);

  localparam logic [1:0] KIND_KEY    = 2'd0;
  localparam logic [1:0] KIND_FINISH = 2'd1;
  localparam logic [1:0] KIND_ENC    = 2'd2;
  localparam logic [1:0] KIND_DEC    = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    rc_t row;
    rc_t col;
  } grid_pos_t;

  // row/column of a cell index; codes past the square map to 0,0
  function automatic grid_pos_t split_cell(cell_addr_t p);
    grid_pos_t g;
    g.row = '0;
    g.col = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (p == cell_addr_t'(r * SIDE + c)) begin
          g.row = rc_t'(r);
          g.col = rc_t'(c);
        end
      end
    end
    return g;
  endfunction

  function automatic cell_addr_t cell_addr(rc_t row, rc_t col);
    logic [CELL_AW+1:0] sum;
    sum = ({3'b000, row} << 2) + {3'b000, row} + {3'b000, col};
    return sum[CELL_AW-1:0];
  endfunction

  function automatic rc_t step_fwd(rc_t v);
    return (v == rc_t'(SIDE - 1)) ? rc_t'(0) : v + rc_t'(1);
  endfunction

  function automatic rc_t step_back(rc_t v);
    return (v == rc_t'(0)) ? rc_t'(SIDE - 1) : v - rc_t'(1);
  endfunction

endpackage

`default_nettype wire

>>> sv/playf_ram.sv
// ---------------------------------------------------------------------------
// playf_ram
// Generic RAM: one write port, two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module playf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic      [WIDTH-1:0]           rdata_a,
  output logic      [WIDTH-1:0]           rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> sv/playf_lane.sv
// ---------------------------------------------------------------------------
// playf_lane
// One letter lane: J to I folding, range check, cell index to row/column.
// ---------------------------------------------------------------------------
`default_nettype none

module playf_lane (
  input  wire logic                  letter_raw_in,
  input  playf_pkg::letter_t         letter_raw,
  input  playf_pkg::cell_addr_t      pos_code,
  output playf_pkg::letter_t         letter_fold,
  output logic                       in_range,
  output playf_pkg::grid_pos_t       where
);
  import playf_pkg::*;

  assign in_range    = letter_raw_in && (letter_raw < letter_t'(LETTERS));
  assign letter_fold = (letter_raw == LETTER_J) ? LETTER_I : letter_raw;
  assign where       = split_cell(pos_code);

endmodule

`default_nettype wire

>>> sv/playf_merge.sv
// ---------------------------------------------------------------------------
// playf_merge
// Combines both lane positions into the two result cell addresses.
// ---------------------------------------------------------------------------
`default_nettype none

module playf_merge (
  input  playf_pkg::grid_pos_t   pos_a,
  input  playf_pkg::grid_pos_t   pos_b,
  input  wire logic              decrypt,
  output playf_pkg::cell_addr_t  addr_a,
  output playf_pkg::cell_addr_t  addr_b
);
  import playf_pkg::*;

  rc_t ca_s;
  rc_t cb_s;
  rc_t ra_s;
  rc_t rb_s;

  always_comb begin
    ca_s = decrypt ? step_back(pos_a.col) : step_fwd(pos_a.col);
    cb_s = decrypt ? step_back(pos_b.col) : step_fwd(pos_b.col);
    ra_s = decrypt ? step_back(pos_a.row) : step_fwd(pos_a.row);
    rb_s = decrypt ? step_back(pos_b.row) : step_fwd(pos_b.row);
    if (pos_a.row == pos_b.row) begin
      addr_a = cell_addr(pos_a.row, ca_s);
      addr_b = cell_addr(pos_b.row, cb_s);
    end else if (pos_a.col == pos_b.col) begin
      addr_a = cell_addr(ra_s, pos_a.col);
      addr_b = cell_addr(rb_s, pos_b.col);
    end else begin
      addr_a = cell_addr(pos_a.row, pos_b.col);
      addr_b = cell_addr(pos_b.row, pos_a.col);
    end
  end

endmodule

`default_nettype wire

>>> sv/playfair_digraph_cipher_unit.sv
// Key letter: result in the cycle after acceptance, busy stays low (1 item per cycle).
// Finish: walks the 26 letters one per cycle, busy high until the result.
// Pair: registered position read, merge, registered square read, then the result;
// busy is high until the result, and the next item is taken in the result cycle.
// Results cannot be stalled. Synchronous rst empties the square: all letters absent.
// ---------------------------------------------------------------------------
// playfair_digraph_cipher_unit
// Playfair 5x5 key square builder and digraph encrypt/decrypt unit.
// ---------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_cipher_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [1:0]          kind,
  input  playf_pkg::letter_t       first_letter,
  input  playf_pkg::letter_t       second_letter,
  output logic                     busy,
  output logic                     done,
  output playf_pkg::letter_t       out_first,
  output playf_pkg::letter_t       out_second,
  output logic [1:0]               status
);
  import playf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_LOOK = 4'b0100,
    ST_READ = 4'b1000
  } state_t;

  state_t               state;
  logic [LETTERS-1:0]   present;
  logic [FILL_W-1:0]    fill_count;
  logic                 ready;
  letter_t              letter_idx;
  logic                 is_dec;
  logic                 err;

  logic                 accept;
  letter_t              a_fold;
  letter_t              b_fold;
  logic                 a_ok;
  logic                 b_ok;
  logic                 a_here;
  logic                 b_here;
  cell_addr_t           pos_rd_a;
  cell_addr_t           pos_rd_b;
  grid_pos_t            where_a;
  grid_pos_t            where_b;
  cell_addr_t           sq_ra;
  cell_addr_t           sq_rb;
  letter_t              sq_rd_a;
  letter_t              sq_rd_b;
  logic                 sq_full;
  logic                 key_place;
  logic                 fill_place;
  logic                 wr_en;
  letter_t              wr_letter;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign sq_full = (fill_count >= FILL_W'(CELLS));
  assign a_here  = a_ok && present[a_fold];
  assign b_here  = b_ok && present[b_fold];

  playf_lane u_lane_a (
    .letter_raw_in (1'b1),
    .letter_raw    (first_letter),
    .pos_code      (pos_rd_a),
    .letter_fold   (a_fold),
    .in_range      (a_ok),
    .where         (where_a)
  );

  playf_lane u_lane_b (
    .letter_raw_in (1'b1),
    .letter_raw    (second_letter),
    .pos_code      (pos_rd_b),
    .letter_fold   (b_fold),
    .in_range      (b_ok),
    .where         (where_b)
  );

  playf_merge u_merge (
    .pos_a   (where_a),
    .pos_b   (where_b),
    .decrypt (is_dec),
    .addr_a  (sq_ra),
    .addr_b  (sq_rb)
  );

  assign key_place  = accept && (kind == KIND_KEY) && !ready && !sq_full && a_ok &&
                      !present[a_fold];
  assign fill_place = (state == ST_FILL) && (letter_idx != LETTER_J) &&
                      !present[letter_idx] && !sq_full;
  assign wr_en      = key_place || fill_place;
  assign wr_letter  = (state == ST_FILL) ? letter_idx : a_fold;

  playf_ram #(
    .WIDTH (CELL_AW),
    .DEPTH (LETTERS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_letter[LETTER_AW-1:0]),
    .wdata   (fill_count[CELL_AW-1:0]),
    .raddr_a (a_fold[LETTER_AW-1:0]),
    .raddr_b (b_fold[LETTER_AW-1:0]),
    .rdata_a (pos_rd_a),
    .rdata_b (pos_rd_b)
  );

  playf_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (CELLS)
  ) u_square_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (fill_count[CELL_AW-1:0]),
    .wdata   (wr_letter),
    .raddr_a (sq_ra),
    .raddr_b (sq_rb),
    .rdata_a (sq_rd_a),
    .rdata_b (sq_rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      present    <= '0;
      fill_count <= '0;
      ready      <= 1'b0;
      done       <= 1'b0;
      out_first  <= '0;
      out_second <= '0;
      status     <= STATUS_OK;
      letter_idx <= '0;
      is_dec     <= 1'b0;
      err        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        present[wr_letter] <= 1'b1;
        fill_count         <= fill_count + FILL_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_KEY: begin
                done       <= 1'b1;
                out_first  <= '0;
                out_second <= '0;
                if (ready || sq_full) begin
                  status <= STATUS_FULL;
                end else if (!a_ok) begin
                  status <= STATUS_MISS;
                end else begin
                  status <= STATUS_OK;
                end
              end
              KIND_FINISH: begin
                if (ready) begin
                  done       <= 1'b1;
                  out_first  <= '0;
                  out_second <= '0;
                  status     <= STATUS_FULL;
                end else begin
                  letter_idx <= '0;
                  state      <= ST_FILL;
                end
              end
              default: begin
                is_dec <= (kind == KIND_DEC);
                err    <= !ready || !a_here || !b_here;
                state  <= ST_LOOK;
              end
            endcase
          end
        end
        ST_FILL: begin
          if (letter_idx == LETTER_Z) begin
            ready      <= 1'b1;
            done       <= 1'b1;
            out_first  <= '0;
            out_second <= '0;
            status     <= STATUS_OK;
            state      <= ST_IDLE;
          end else begin
            letter_idx <= letter_idx + letter_t'(1);
          end
        end
        ST_LOOK: begin
          state <= ST_READ;
        end
        ST_READ: begin
          done       <= 1'b1;
          out_first  <= err ? letter_t'(0) : sq_rd_a;
          out_second <= err ? letter_t'(0) : sq_rd_b;
          status     <= err ? STATUS_MISS : STATUS_OK;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/playf_checker.sv
// ---------------------------------------------------------------------------
// playf_checker
// Port-level checks on the Playfair cipher unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module playf_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input playf_pkg::letter_t       out_first,
  input playf_pkg::letter_t       out_second,
  input wire logic [1:0]          status
);
  import playf_pkg::*;

  logic accept;
  logic failed;
  logic letters_zero;
  logic status_known;

  assign accept       = start && !busy;
  assign failed       = done && (status != STATUS_OK);
  assign letters_zero = (out_first == '0) && (out_second == '0);
  assign status_known = (status == STATUS_OK) || (status == STATUS_MISS) ||
                        (status == STATUS_FULL);

  `CHK_ASSERT_NR(a_reset_quiet, clk, rst |=> (!done && !busy), "not quiet after reset")
  `CHK_ASSERT(a_accept_answered, clk, rst, accept |=> (done || busy), "transaction dropped")
  `CHK_ASSERT(a_busy_from_accept, clk, rst, $rose(busy) |-> $past(start), "busy without start")
  `CHK_ASSERT(a_error_zero, clk, rst, failed |-> letters_zero, "nonzero letters on error")
  `CHK_ASSERT(a_status_code, clk, rst, done |-> status_known, "undefined status code")

endmodule

bind playfair_digraph_cipher_unit playf_checker u_playf_checker (.*);

`default_nettype wire

>>> sim/tb_playfair_digraph_cipher_unit.sv
// ---------------------------------------------------------------------------
// tb_playfair_digraph_cipher_unit
// Self-checking bench for the Playfair key square builder and digraph unit.
// Key letters, the finish item and cipher pairs are driven over the
// start/busy handshake. A built-in square model predicts each result, and
// the results are checked in order as done strobes them. Directed items cover
// the unready square, J folding, duplicate and out-of-range letters, repeated
// finish, and the row, column, rectangle and identical-letter rules. Random
// pair traffic follows with and without sender gaps.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_playfair_digraph_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import playf_pkg::*;

  localparam int     RANDOM_ITEMS = 660;
  localparam int     DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT  = 200000;

  typedef struct packed {
    letter_t    first;
    letter_t    second;
    logic [1:0] status;
  } digraph_out_t;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       start         = 1'b0;
  logic [1:0] kind          = KIND_KEY;
  letter_t    first_letter  = '0;
  letter_t    second_letter = '0;
  logic       busy;
  logic       done;
  letter_t    out_first;
  letter_t    out_second;
  logic [1:0] status;

  // square model
  letter_t      sq_letter [CELLS];
  logic [5:0]   sq_slot   [LETTERS];
  int           sq_fill;
  bit           sq_ready;
  digraph_out_t outcome_q [$];

  int     errors   = 0;
  int     idle_pct = 0;
  longint cycles   = 0;

  playfair_digraph_cipher_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .busy          (busy),
    .done          (done),
    .out_first     (out_first),
    .out_second    (out_second),
    .status        (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("playfair_digraph_cipher_unit regression: fail");
      $finish;
    end
  end

  function automatic letter_t fold_j(letter_t raw);
    return (raw == LETTER_J) ? LETTER_I : raw;
  endfunction

  function automatic void sq_place(letter_t l);
    if (sq_fill < CELLS) begin
      sq_letter[sq_fill] = l;
      sq_slot[l] = 6'(sq_fill);
      sq_fill++;
    end
  endfunction

  function automatic digraph_out_t playfair_outcome(logic [1:0] k, letter_t a_raw,
                                                    letter_t b_raw);
    digraph_out_t r;
    letter_t      a;
    letter_t      b;
    int           pa, pb, ra, ca, rb, cb, sh;
    r = '0;
    a = fold_j(a_raw);
    b = fold_j(b_raw);
    case (k)
      KIND_KEY: begin
        if (sq_ready || sq_fill >= CELLS) r.status = STATUS_FULL;
        else if (a_raw >= LETTERS) r.status = STATUS_MISS;
        else if (sq_slot[a][5]) sq_place(a);
      end
      KIND_FINISH: begin
        if (sq_ready) begin
          r.status = STATUS_FULL;
        end else begin
          for (int l = 0; l < LETTERS; l++) begin
            if (letter_t'(l) != LETTER_J && sq_slot[l][5]) sq_place(letter_t'(l));
          end
          sq_ready = 1'b1;
        end
      end
      default: begin
        if (!sq_ready || a_raw >= LETTERS || b_raw >= LETTERS) begin
          r.status = STATUS_MISS;
        end else if (sq_slot[a][5] || sq_slot[b][5]) begin
          r.status = STATUS_MISS;
        end else begin
          pa = sq_slot[a][4:0];
          pb = sq_slot[b][4:0];
          ra = pa / SIDE;
          ca = pa % SIDE;
          rb = pb / SIDE;
          cb = pb % SIDE;
          sh = (k == KIND_ENC) ? 1 : SIDE - 1;
          if (ra == rb) begin
            r.first  = sq_letter[ra * SIDE + (ca + sh) % SIDE];
            r.second = sq_letter[rb * SIDE + (cb + sh) % SIDE];
          end else if (ca == cb) begin
            r.first  = sq_letter[((ra + sh) % SIDE) * SIDE + ca];
            r.second = sq_letter[((rb + sh) % SIDE) * SIDE + cb];
          end else begin
            r.first  = sq_letter[ra * SIDE + cb];
            r.second = sq_letter[rb * SIDE + ca];
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(logic [1:0] k, letter_t a, letter_t b);
    int gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    first_letter  <= a;
    second_letter <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    outcome_q = {outcome_q, playfair_outcome(k, a, b)};
  endtask

  // one result per transaction, in order
  always @(posedge clk) begin
    digraph_out_t want;
    if (!rst && done === 1'b1) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected transaction: out_first %0d out_second %0d status %0d",
               out_first, out_second, status);
        errors++;
      end else begin
        want = outcome_q.pop_front();
        if (out_first !== want.first) begin
          $error("out_first: expected %0d, got %0d", want.first, out_first);
          errors++;
        end
        if (out_second !== want.second) begin
          $error("out_second: expected %0d, got %0d", want.second, out_second);
          errors++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          errors++;
        end
      end
    end
  end

  task automatic test_unready_square;
    send_item(KIND_ENC, letter_t'(0), LETTER_Z);
    send_item(KIND_DEC, letter_t'(31), letter_t'(31));
    send_item(KIND_KEY, letter_t'(31), letter_t'(0));
    send_item(KIND_KEY, letter_t'(26), letter_t'(31));
  endtask

  task automatic test_key_entry;
    int target;
    target = ($urandom_range(3) == 0) ? CELLS : $urandom_range(4, CELLS - 1);
    send_item(KIND_KEY, LETTER_J, letter_t'($urandom_range(31)));
    send_item(KIND_KEY, LETTER_I, letter_t'($urandom_range(31)));
    send_item(KIND_KEY, letter_t'(0), letter_t'($urandom_range(31)));
    send_item(KIND_KEY, LETTER_Z, letter_t'($urandom_range(31)));
    send_item(KIND_KEY, letter_t'(0), letter_t'($urandom_range(31)));
    idle_pct = 27;
    while (sq_fill < target) begin
      if ($urandom_range(9) == 0)
        send_item(KIND_KEY, letter_t'($urandom_range(26, 31)), letter_t'($urandom_range(31)));
      else
        send_item(KIND_KEY, letter_t'($urandom_range(25)), letter_t'($urandom_range(31)));
    end
    idle_pct = 0;
    // square filled by key letters alone
    if (sq_fill == CELLS) begin
      send_item(KIND_KEY, letter_t'(0), letter_t'(0));
      send_item(KIND_KEY, letter_t'(31), letter_t'(31));
    end
  endtask

  task automatic test_finish;
    send_item(KIND_FINISH, letter_t'($urandom_range(31)), letter_t'($urandom_range(31)));
    send_item(KIND_FINISH, letter_t'($urandom_range(31)), letter_t'($urandom_range(31)));
    send_item(KIND_KEY, letter_t'($urandom_range(31)), letter_t'($urandom_range(31)));
  endtask

  task automatic test_cipher_rules;
    logic [1:0] k;
    for (int i = 0; i < 2; i++) begin
      k = (i == 0) ? KIND_ENC : KIND_DEC;
      send_item(k, sq_letter[3], sq_letter[4]);
      send_item(k, sq_letter[2], sq_letter[22]);
      send_item(k, sq_letter[0], sq_letter[24]);
      send_item(k, sq_letter[12], sq_letter[12]);
      send_item(k, LETTER_J, sq_letter[7]);
      send_item(k, letter_t'(0), LETTER_Z);
      send_item(k, letter_t'(26), letter_t'(0));
      send_item(k, letter_t'(0), letter_t'(31));
    end
  endtask

  task automatic test_random_traffic;
    int         phase_pct [3] = '{0, 59, 27};
    logic [1:0] k;
    int         pa, pb;
    letter_t    a, b;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_pct[ph];
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        if ($urandom_range(99) < 8) begin
          send_item(2'($urandom_range(3)), letter_t'($urandom_range(31)),
                    letter_t'($urandom_range(31)));
        end else begin
          k  = $urandom_range(1) ? KIND_ENC : KIND_DEC;
          pa = $urandom_range(CELLS - 1);
          case ($urandom_range(3))
            0:       pb = (pa / SIDE) * SIDE + $urandom_range(SIDE - 1);
            1:       pb = $urandom_range(SIDE - 1) * SIDE + pa % SIDE;
            2:       pb = pa;
            default: pb = $urandom_range(CELLS - 1);
          endcase
          a = sq_letter[pa];
          b = sq_letter[pb];
          if (a == LETTER_I && $urandom_range(1)) a = LETTER_J;
          if (b == LETTER_I && $urandom_range(1)) b = LETTER_J;
          send_item(k, a, b);
        end
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    foreach (sq_letter[i]) sq_letter[i] = '0;
    foreach (sq_slot[i]) sq_slot[i] = 6'h20;
    sq_fill  = 0;
    sq_ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_unready_square;
    test_key_entry;
    test_finish;
    test_cipher_rules;
    test_random_traffic;
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("playfair_digraph_cipher_unit regression: pass");
    else
      $display("playfair_digraph_cipher_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/playf_pkg.sv
sv/playf_ram.sv
sv/playf_lane.sv
sv/playf_merge.sv
sv/playfair_digraph_cipher_unit.sv
sv/playf_checker.sv
sim/tb_playfair_digraph_cipher_unit.sv
